FILE: rtl/eqtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Event-queued table FSM package
// Operation codes, register indexes and storage layouts shared by the block.
// ----------------------------------------------------------------------------
package eqtf_pkg;

   // request operation codes
   localparam logic [1:0] OP_POST  = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // configuration register indexes
   localparam logic CSR_INITIAL_STATE  = 1'b0;
   localparam logic CSR_ENTRIES_IN_USE = 1'b1;

   localparam int CSR_DATA_W = 8;
   localparam int ENTRIES_W  = 5;

   // one transition entry
   typedef struct packed {
      logic [7:0] action;
      logic [7:0] to_state;
      logic [7:0] from_state;
      logic [7:0] evt;
   } entry_type;

   // one queued event
   typedef struct packed {
      logic [7:0]  evt;
      logic [31:0] payload;
   } ring_entry_type;

endpackage
`default_nettype wire

FILE: rtl/event_queued_table_fsm.sv
`default_nettype none
// Post, write-entry and unknown requests go straight to the done state, where
// the result register is loaded. A run request pops the oldest event and then
// compares up to min(entries_in_use, TABLE_DEPTH) entries, one per cycle and
// stopping at a match, through the single registered read port of the table.
// One request at a time; the next is taken once the result is registered.
// Synchronous reset clears the ring pointers, state (to 0) and last action;
// ring and table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Event-queued table FSM
// Programmable state machine with an event ring and a sequential search
// over a transition table held in memory.
// ----------------------------------------------------------------------------
module event_queued_table_fsm #(
   parameter int QUEUE_DEPTH = 5,
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_event_code,
   input  wire logic [31:0] req_event_payload,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic [7:0]  req_entry_event,
   input  wire logic [7:0]  req_entry_state,
   input  wire logic [7:0]  req_entry_next_state,
   input  wire logic [7:0]  req_entry_action,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_post_accepted,
   output      logic        rsp_fired,
   output      logic [7:0]  rsp_action_code,
   output      logic [31:0] rsp_fired_payload,
   output      logic [7:0]  rsp_present_state,
   output      logic [2:0]  rsp_queued_events,

   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [eqtf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW   = CNTW + 1;
   localparam int TIW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   eqtf_pkg::ring_entry_type ring_mem [QUEUE_DEPTH];
   eqtf_pkg::entry_type      table_mem [TABLE_DEPTH];

   logic [1:0]      state_ff, state_in;
   logic [QIW-1:0]  head_ff, head_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [7:0]      state_now_ff, state_now_in;
   logic [7:0]      last_action_ff, last_action_in;
   logic [eqtf_pkg::ENTRIES_W-1:0] entries_ff, entries_in;
   logic [CW-1:0]   lim_ff, lim_in;
   logic [CW-1:0]   addr_ff, addr_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic            acc_ff, acc_in;
   logic            fired_ff, fired_in;
   logic            rsp_valid_ff, rsp_valid_in;

   eqtf_pkg::ring_entry_type ring_rd_ff;
   eqtf_pkg::entry_type      tbl_rd_ff;

   logic [31:0]     rsp_payload_ff;
   logic            rsp_acc_ff, rsp_fired_ff;
   logic [7:0]      rsp_action_ff, rsp_state_ff;
   logic [2:0]      rsp_count_ff;

   logic            req_fire;
   logic            rsp_load;
   logic            ring_full;
   logic [SW-1:0]   tail_sum;
   logic [QIW-1:0]  tail_idx;
   logic [QIW-1:0]  head_next;
   logic [CW-1:0]   lim_calc;
   logic            issue;
   logic            match;
   logic            tbl_wr_ok;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign ring_full = (count_ff == CNTW'(QUEUE_DEPTH));
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_idx  = (tail_sum >= SW'(QUEUE_DEPTH)) ? QIW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : QIW'(tail_sum);
   assign head_next = (head_ff == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // clamp the search length to the table size
   assign lim_calc  = (int'(entries_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                       : CW'(entries_ff);
   assign tbl_wr_ok = (int'(req_entry_index) < TABLE_DEPTH);

   assign issue = (state_ff == ST_SEARCH) && (addr_ff < lim_ff);
   assign match = (tbl_rd_ff.evt == ring_rd_ff.evt) &&
                  (tbl_rd_ff.from_state == state_now_ff);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      state_now_in   = state_now_ff;
      last_action_in = last_action_ff;
      entries_in     = entries_ff;
      lim_in         = lim_ff;
      addr_in        = addr_ff;
      cmp_vld_in     = cmp_vld_ff;
      acc_in         = acc_ff;
      fired_in       = fired_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               acc_in   = 1'b0;
               fired_in = 1'b0;
               state_in = ST_DONE;
               unique case (req_operation)
                  eqtf_pkg::OP_POST: begin
                     if (!ring_full) begin
                        count_in = count_ff + 1'b1;
                        acc_in   = 1'b1;
                     end
                  end
                  eqtf_pkg::OP_RUN: begin
                     // pop the oldest event; an empty ring leaves everything alone
                     if (count_ff != '0) begin
                        head_in  = head_next;
                        count_in = count_ff - 1'b1;
                        if (lim_calc != '0) begin
                           state_in   = ST_SEARCH;
                           lim_in     = lim_calc;
                           addr_in    = '0;
                           cmp_vld_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // read one entry ahead, compare the one fetched last cycle
            cmp_vld_in = issue;
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            if (cmp_vld_ff && match) begin
               fired_in       = 1'b1;
               state_now_in   = tbl_rd_ff.to_state;
               last_action_in = tbl_rd_ff.action;
               state_in       = ST_DONE;
            end else if (addr_ff == lim_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            eqtf_pkg::CSR_INITIAL_STATE:  state_now_in = csr_wdata;
            eqtf_pkg::CSR_ENTRIES_IN_USE: entries_in   = csr_wdata[eqtf_pkg::ENTRIES_W-1:0];
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         state_now_ff   <= '0;
         last_action_ff <= '0;
         entries_ff     <= '0;
         lim_ff         <= '0;
         addr_ff        <= '0;
         cmp_vld_ff     <= 1'b0;
         acc_ff         <= 1'b0;
         fired_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         state_now_ff   <= state_now_in;
         last_action_ff <= last_action_in;
         entries_ff     <= entries_in;
         lim_ff         <= lim_in;
         addr_ff        <= addr_in;
         cmp_vld_ff     <= cmp_vld_in;
         acc_ff         <= acc_in;
         fired_ff       <= fired_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // event ring: write at the tail, hold the head entry while busy
   always_ff @(posedge clock) begin
      if (req_fire && (req_operation == eqtf_pkg::OP_POST) && !ring_full) begin
         ring_mem[tail_idx] <= '{evt: req_event_code, payload: req_event_payload};
      end
      if (state_ff == ST_IDLE) begin
         ring_rd_ff <= ring_mem[head_ff];
      end
   end

   // transition table
   always_ff @(posedge clock) begin
      if (req_fire && (req_operation == eqtf_pkg::OP_WRITE) && tbl_wr_ok) begin
         table_mem[TIW'(req_entry_index)] <= '{action:     req_entry_action,
                                               to_state:   req_entry_next_state,
                                               from_state: req_entry_state,
                                               evt:        req_entry_event};
      end
      if (issue) begin
         tbl_rd_ff <= table_mem[addr_ff[TIW-1:0]];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_acc_ff     <= acc_ff;
         rsp_fired_ff   <= fired_ff;
         rsp_action_ff  <= last_action_ff;
         rsp_payload_ff <= fired_ff ? ring_rd_ff.payload : 32'd0;
         rsp_state_ff   <= state_now_ff;
         rsp_count_ff   <= 3'(count_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_post_accepted = rsp_acc_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_action_code   = rsp_action_ff;
   assign rsp_fired_payload = rsp_payload_ff;
   assign rsp_present_state = rsp_state_ff;
   assign rsp_queued_events = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNTW'(QUEUE_DEPTH)) && (int'(head_ff) < QUEUE_DEPTH))
      else $error("ring pointer or count out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done state");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((addr_ff <= lim_ff) && (lim_ff != '0)))
      else $error("search address past the entry limit");

endmodule
`default_nettype wire
